>>> design/ces_pkg.sv
// Shared constants and types for the color error statistics block.
`timescale 1ns / 1ps
package ces_pkg;

  localparam int MAX_PAIRS = 65536;
  localparam int CH_BITS   = 16;
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

  localparam logic [15:0] CH_MASK    = 16'((32'd1 << CH_BITS) - 32'd1);
  localparam logic [8:0]  WEIGHT_ONE = 9'd256;
  localparam int          RATIO_FRAC = 14;
  localparam logic [21:0] RATIO_CAP  = 22'(255 << RATIO_FRAC);

  localparam logic [63:0] FULL_SCALE = (64'd1 << CH_BITS) - 64'd1;
  localparam logic [63:0] TSS_TINY   = FULL_SCALE * FULL_SCALE * 64'd256 / 64'd1000000;

  localparam logic [17:0] R2_ONE = 18'd16384;
  localparam logic [17:0] R2_MIN = 18'h20000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [6:0] DIV_STEPS_FULL  = 7'd64;
  localparam logic [6:0] DIV_STEPS_RATIO = 7'(16 + RATIO_FRAC);
  localparam logic [6:0] DIV_STEPS_FRAC  = 7'(RATIO_FRAC);

  typedef struct packed {
    logic [2:0][16:0] err;
    logic [2:0][15:0] ae;
    logic [2:0][15:0] refc;
    logic [8:0]       w;
    logic             last;
  } ces_word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] init_rem;
    logic [63:0] num;
    logic [63:0] den;
    logic [6:0]  steps;
  } ces_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } ces_div_rsp_t;

endpackage

>>> design/ces_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ces_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ces_pkg::ces_div_req_t req,
  output ces_pkg::ces_div_rsp_t rsp
);
  import ces_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] num_r;
  logic [63:0] den_r;
  logic [63:0] quo_r;
  logic [64:0] trial;
  logic [63:0] rem_nxt;
  logic        qbit;

  always_comb begin
    trial = {rem_r, num_r[63]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = 64'(trial - {1'b0, den_r});
      qbit    = 1'b1;
    end else begin
      rem_nxt = trial[63:0];
      qbit    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        rem_r  <= req.init_rem;
        num_r  <= req.num;
        den_r  <= req.den;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[62:0], 1'b0};
        quo_r <= {quo_r[62:0], qbit};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> design/ces_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module ces_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);
  import ces_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] sum;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= val;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
      end else if (busy_r) begin
        if (v_r >= sum) begin
          v_r   <= v_r - sum;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

>>> design/ces_fifo.sv
// Short word queue between the front and back parts.
`timescale 1ns / 1ps
module ces_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ces_pkg::ces_word_t push_data,
  output logic               full,
  input  logic               pop,
  output ces_pkg::ces_word_t pop_data,
  output logic               empty
);
  import ces_pkg::*;

  ces_word_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full     = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> design/ces_front.sv
// Front part: takes input words, forms channel errors and weight, feeds the queue.
`timescale 1ns / 1ps
module ces_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_corrected_c0,
  input  logic [15:0]        in_corrected_c1,
  input  logic [15:0]        in_corrected_c2,
  input  logic [15:0]        in_reference_c0,
  input  logic [15:0]        in_reference_c1,
  input  logic [15:0]        in_reference_c2,
  input  logic [8:0]         in_confidence,
  input  logic               in_final_item,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               push,
  output ces_pkg::ces_word_t push_data,
  input  logic               full
);
  import ces_pkg::*;

  logic        use_conf_r;
  logic        word_valid_r;
  ces_word_t   word_r;
  ces_word_t   word_nxt;
  logic [15:0] cor [3];
  logic [15:0] rfc [3];
  logic [16:0] e;
  logic        accept;

  assign cor[0] = in_corrected_c0 & CH_MASK;
  assign cor[1] = in_corrected_c1 & CH_MASK;
  assign cor[2] = in_corrected_c2 & CH_MASK;
  assign rfc[0] = in_reference_c0 & CH_MASK;
  assign rfc[1] = in_reference_c1 & CH_MASK;
  assign rfc[2] = in_reference_c2 & CH_MASK;

  always_comb begin
    word_nxt = '0;
    e        = '0;
    for (int c = 0; c < 3; c++) begin
      e                 = {1'b0, cor[c]} - {1'b0, rfc[c]};
      word_nxt.err[c]   = e;
      word_nxt.ae[c]    = e[16] ? 16'(-e) : e[15:0];
      word_nxt.refc[c]  = rfc[c];
    end
    if (!use_conf_r)                  word_nxt.w = WEIGHT_ONE;
    else if (in_confidence > WEIGHT_ONE) word_nxt.w = WEIGHT_ONE;
    else                              word_nxt.w = in_confidence;
    word_nxt.last = in_final_item;
  end

  assign in_stall  = word_valid_r && full;
  assign accept    = in_valid && !in_stall;
  assign push      = word_valid_r && !full;
  assign push_data = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_conf_r   <= 1'b1;
      word_valid_r <= 1'b0;
    end else begin
      if (cfg_we) use_conf_r <= cfg_data;
      if (accept) begin
        word_valid_r <= 1'b1;
        word_r       <= word_nxt;
      end else if (push) begin
        word_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> design/ces_back.sv
// Back part: accumulates queued words and works out the run statistics.
`timescale 1ns / 1ps
module ces_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ces_pkg::ces_word_t  word_in,
  input  logic                word_empty,
  output logic                word_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_channel,
  output logic signed [16:0]  out_mean_error,
  output logic [15:0]         out_std_error,
  output logic [15:0]         out_max_abs_error,
  output logic [16:0]         out_rmse,
  output logic [17:0]         out_mae,
  output logic [23:0]         out_mape,
  output logic signed [17:0]  out_r2_score,
  output logic                out_weight_valid,
  output logic                out_last_result
);
  import ces_pkg::*;

  typedef enum logic [30:0] {
    ST_IDLE    = 31'd1 << 0,
    ST_CHK     = 31'd1 << 1,
    ST_RATIO   = 31'd1 << 2,
    ST_RWAIT   = 31'd1 << 3,
    ST_MUL     = 31'd1 << 4,
    ST_ADD     = 31'd1 << 5,
    ST_WMUL    = 31'd1 << 6,
    ST_WADD    = 31'd1 << 7,
    ST_FIN     = 31'd1 << 8,
    ST_RMSE_D  = 31'd1 << 9,
    ST_RMSE_S  = 31'd1 << 10,
    ST_MAE     = 31'd1 << 11,
    ST_MAPE0   = 31'd1 << 12,
    ST_MAPE    = 31'd1 << 13,
    ST_R2_MS   = 31'd1 << 14,
    ST_R2_MW   = 31'd1 << 15,
    ST_R2_P1   = 31'd1 << 16,
    ST_R2_P2   = 31'd1 << 17,
    ST_R2_P3   = 31'd1 << 18,
    ST_R2_Q    = 31'd1 << 19,
    ST_R2_QW   = 31'd1 << 20,
    ST_R2_FW   = 31'd1 << 21,
    ST_C_ST    = 31'd1 << 22,
    ST_C_D1    = 31'd1 << 23,
    ST_C_P     = 31'd1 << 24,
    ST_C_D2S   = 31'd1 << 25,
    ST_C_D2    = 31'd1 << 26,
    ST_C_D3S   = 31'd1 << 27,
    ST_C_D3    = 31'd1 << 28,
    ST_C_S     = 31'd1 << 29,
    ST_EMIT    = 31'd1 << 30
  } state_t;

  state_t       state_r;
  ces_word_t    cur_r;
  logic [1:0]   ch_r;

  logic [CNT_W-1:0]   pair_cnt_r;
  logic signed [32:0] err_sum_r  [3];
  logic [47:0]        sq_sum_r   [3];
  logic [15:0]        max_r      [3];
  logic [31:0]        ref_sum_r  [3];
  logic [40:0]        wref_sum_r [3];
  logic [24:0]        w_tot_r;
  logic [57:0]        wse_r;
  logic [41:0]        wae_r;
  logic [49:0]        wrs_r;
  logic [57:0]        wrsq_r;

  logic [23:0] ratio_all_r;
  logic [31:0] sq_r;
  logic [31:0] rsq_r;
  logic [24:0] wr_r;
  logic [33:0] sq_all_r;
  logic [17:0] abs_all_r;
  logic [33:0] refsq_all_r;
  logic [42:0] pw_sq_r;
  logic [26:0] pw_abs_r;
  logic [32:0] pw_rat_r;
  logic [42:0] pw_rsq_r;

  logic        valid_r;
  logic [16:0] rmse_r;
  logic [17:0] mae_r;
  logic [23:0] mape_r;
  logic [17:0] r2_r;
  logic [63:0] mape_num_r;
  logic [15:0] m_r;
  logic [31:0] mm_r;
  logic [56:0] m2w_r;
  logic [56:0] mmw_r;
  logic [63:0] tss_r;
  logic [32:0] q_r;
  logic [16:0] r_r;
  logic [63:0] qm_r;
  logic [49:0] rm_r;
  logic [63:0] vn_r;
  logic [16:0] mean_r [3];
  logic [15:0] sd_r   [3];

  ces_div_req_t dreq_r;
  ces_div_rsp_t drsp;
  logic         sq_start_r;
  logic [63:0]  sq_val_r;
  logic         sq_done;
  logic [31:0]  sq_root;

  logic                out_valid_r;
  logic [1:0]          o_channel_r;
  logic [16:0]         o_mean_r;
  logic [15:0]         o_sd_r;
  logic [15:0]         o_max_r;
  logic [16:0]         o_rmse_r;
  logic [17:0]         o_mae_r;
  logic [23:0]         o_mape_r;
  logic [17:0]         o_r2_r;
  logic                o_valid_r;
  logic                o_last_r;

  logic [16:0] e_c;
  logic [15:0] ae_c;
  logic [15:0] ref_c;
  logic [32:0] mag_c;
  logic [63:0] n64;
  logic [63:0] mape_den;
  logic        emit_ok;

  function automatic ces_div_req_t mk_div(input logic [63:0] init_rem, input logic [63:0] num,
                                          input logic [63:0] den, input logic [6:0] steps);
    ces_div_req_t r;
    r.start    = 1'b1;
    r.init_rem = init_rem;
    r.num      = num;
    r.den      = den;
    r.steps    = steps;
    return r;
  endfunction

  ces_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq_r),
    .rsp   (drsp)
  );

  ces_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start_r),
    .val   (sq_val_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign e_c      = cur_r.err[ch_r];
  assign ae_c     = cur_r.ae[ch_r];
  assign ref_c    = cur_r.refc[ch_r];
  assign mag_c    = err_sum_r[ch_r][32] ? 33'(-err_sum_r[ch_r]) : 33'(err_sum_r[ch_r]);
  assign n64      = 64'(pair_cnt_r);
  assign mape_den = (64'(w_tot_r) << 11) + (64'(w_tot_r) << 10);
  assign emit_ok  = !out_valid_r || !out_stall;
  assign word_pop = (state_r == ST_IDLE) && !word_empty;

  always_ff @(posedge clk) begin
    if (word_pop) cur_r <= word_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      dreq_r      <= '0;
      sq_start_r  <= 1'b0;
      pair_cnt_r  <= '0;
      w_tot_r     <= '0;
      wse_r       <= '0;
      wae_r       <= '0;
      wrs_r       <= '0;
      wrsq_r      <= '0;
      for (int c = 0; c < 3; c++) begin
        err_sum_r[c]  <= '0;
        sq_sum_r[c]   <= '0;
        max_r[c]      <= '0;
        ref_sum_r[c]  <= '0;
        wref_sum_r[c] <= '0;
      end
    end else begin
      dreq_r.start <= 1'b0;
      sq_start_r   <= 1'b0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (!word_empty) state_r <= ST_CHK;
        end
        ST_CHK: begin
          ch_r        <= '0;
          ratio_all_r <= '0;
          sq_all_r    <= '0;
          abs_all_r   <= '0;
          refsq_all_r <= '0;
          if (pair_cnt_r < CNT_W'(MAX_PAIRS)) state_r <= ST_RATIO;
          else if (cur_r.last)                state_r <= ST_FIN;
          else                                state_r <= ST_IDLE;
        end
        ST_RATIO: begin
          if (ref_c != '0) begin
            dreq_r  <= mk_div('0, {ae_c, 48'd0}, 64'(ref_c), DIV_STEPS_RATIO);
            state_r <= ST_RWAIT;
          end else if (ch_r == 2'd2) begin
            ch_r    <= '0;
            state_r <= ST_MUL;
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_RWAIT: begin
          if (drsp.done) begin
            if (drsp.quo > 64'(RATIO_CAP)) ratio_all_r <= ratio_all_r + 24'(RATIO_CAP);
            else ratio_all_r <= ratio_all_r + 24'(drsp.quo[21:0]);
            if (ch_r == 2'd2) begin
              ch_r    <= '0;
              state_r <= ST_MUL;
            end else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= ST_RATIO;
            end
          end
        end
        ST_MUL: begin
          sq_r    <= 32'(ae_c) * 32'(ae_c);
          rsq_r   <= 32'(ref_c) * 32'(ref_c);
          wr_r    <= 25'(cur_r.w) * 25'(ref_c);
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          err_sum_r[ch_r]  <= err_sum_r[ch_r] + 33'($signed(e_c));
          sq_sum_r[ch_r]   <= sq_sum_r[ch_r] + 48'(sq_r);
          if (ae_c > max_r[ch_r]) max_r[ch_r] <= ae_c;
          ref_sum_r[ch_r]  <= ref_sum_r[ch_r] + 32'(ref_c);
          wref_sum_r[ch_r] <= wref_sum_r[ch_r] + 41'(wr_r);
          sq_all_r         <= sq_all_r + 34'(sq_r);
          abs_all_r        <= abs_all_r + 18'(ae_c);
          refsq_all_r      <= refsq_all_r + 34'(rsq_r);
          if (ch_r == 2'd2) begin
            ch_r    <= '0;
            state_r <= ST_WMUL;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_WMUL: begin
          pw_sq_r  <= 43'(cur_r.w) * 43'(sq_all_r);
          pw_abs_r <= 27'(cur_r.w) * 27'(abs_all_r);
          pw_rat_r <= 33'(cur_r.w) * 33'(ratio_all_r);
          pw_rsq_r <= 43'(cur_r.w) * 43'(refsq_all_r);
          state_r  <= ST_WADD;
        end
        ST_WADD: begin
          wse_r      <= wse_r + 58'(pw_sq_r);
          wae_r      <= wae_r + 42'(pw_abs_r);
          wrs_r      <= wrs_r + 50'(pw_rat_r);
          wrsq_r     <= wrsq_r + 58'(pw_rsq_r);
          w_tot_r    <= w_tot_r + 25'(cur_r.w);
          pair_cnt_r <= pair_cnt_r + 1'b1;
          state_r    <= cur_r.last ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (w_tot_r == '0) begin
            valid_r <= 1'b0;
            rmse_r  <= '0;
            mae_r   <= '0;
            mape_r  <= '0;
            r2_r    <= '0;
            ch_r    <= '0;
            state_r <= ST_C_ST;
          end else begin
            valid_r <= 1'b1;
            dreq_r  <= mk_div('0, 64'(wse_r), 64'(w_tot_r), DIV_STEPS_FULL);
            state_r <= ST_RMSE_D;
          end
        end
        ST_RMSE_D: begin
          if (drsp.done) begin
            sq_start_r <= 1'b1;
            sq_val_r   <= drsp.quo;
            state_r    <= ST_RMSE_S;
          end
        end
        ST_RMSE_S: begin
          if (sq_done) begin
            rmse_r  <= (sq_root > 32'h1FFFF) ? 17'h1FFFF : sq_root[16:0];
            dreq_r  <= mk_div('0, 64'(wae_r), 64'(w_tot_r), DIV_STEPS_FULL);
            state_r <= ST_MAE;
          end
        end
        ST_MAE: begin
          if (drsp.done) begin
            mae_r      <= (drsp.quo > 64'h3FFFF) ? 18'h3FFFF : drsp.quo[17:0];
            mape_num_r <= 64'(wrs_r) * 64'd625;
            state_r    <= ST_MAPE0;
          end
        end
        ST_MAPE0: begin
          dreq_r  <= mk_div('0, mape_num_r, mape_den, DIV_STEPS_FULL);
          state_r <= ST_MAPE;
        end
        ST_MAPE: begin
          if (drsp.done) begin
            mape_r <= (drsp.quo > 64'hFFFFFF) ? 24'hFFFFFF : drsp.quo[23:0];
            ch_r   <= '0;
            tss_r  <= 64'(wrsq_r);
            if (pair_cnt_r == '0) begin
              r2_r    <= '0;
              state_r <= ST_C_ST;
            end else begin
              state_r <= ST_R2_MS;
            end
          end
        end
        ST_R2_MS: begin
          dreq_r  <= mk_div('0, 64'(ref_sum_r[ch_r]) + (n64 >> 1), n64, DIV_STEPS_FULL);
          state_r <= ST_R2_MW;
        end
        ST_R2_MW: begin
          if (drsp.done) begin
            m_r     <= drsp.quo[15:0];
            state_r <= ST_R2_P1;
          end
        end
        ST_R2_P1: begin
          mm_r    <= 32'(m_r) * 32'(m_r);
          m2w_r   <= 57'(m_r) * 57'(wref_sum_r[ch_r]);
          state_r <= ST_R2_P2;
        end
        ST_R2_P2: begin
          mmw_r   <= 57'(mm_r) * 57'(w_tot_r);
          state_r <= ST_R2_P3;
        end
        ST_R2_P3: begin
          tss_r <= tss_r + 64'(mmw_r) - 64'({m2w_r, 1'b0});
          if (ch_r == 2'd2) begin
            ch_r    <= '0;
            state_r <= ST_R2_Q;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= ST_R2_MS;
          end
        end
        ST_R2_Q: begin
          if (tss_r <= TSS_TINY) begin
            r2_r    <= '0;
            state_r <= ST_C_ST;
          end else begin
            dreq_r  <= mk_div('0, 64'(wse_r), tss_r, DIV_STEPS_FULL);
            state_r <= ST_R2_QW;
          end
        end
        ST_R2_QW: begin
          if (drsp.done) begin
            if (drsp.quo >= 64'd9) begin
              r2_r    <= R2_MIN;
              state_r <= ST_C_ST;
            end else begin
              q_r     <= 33'(drsp.quo[3:0]);
              dreq_r  <= mk_div(drsp.rem, '0, tss_r, DIV_STEPS_FRAC);
              state_r <= ST_R2_FW;
            end
          end
        end
        ST_R2_FW: begin
          if (drsp.done) begin
            r2_r    <= R2_ONE - 18'({q_r[3:0], 14'd0}) - 18'(drsp.quo[13:0]);
            state_r <= ST_C_ST;
          end
        end
        ST_C_ST: begin
          if (pair_cnt_r == '0) begin
            mean_r[ch_r] <= '0;
            sd_r[ch_r]   <= '0;
            if (ch_r == 2'd2) begin
              ch_r    <= '0;
              state_r <= ST_EMIT;
            end else begin
              ch_r <= ch_r + 2'd1;
            end
          end else begin
            dreq_r  <= mk_div('0, 64'(mag_c), n64, DIV_STEPS_FULL);
            state_r <= ST_C_D1;
          end
        end
        ST_C_D1: begin
          if (drsp.done) begin
            q_r          <= drsp.quo[32:0];
            r_r          <= drsp.rem[16:0];
            mean_r[ch_r] <= err_sum_r[ch_r][32] ? 17'(-drsp.quo[16:0]) : drsp.quo[16:0];
            state_r      <= ST_C_P;
          end
        end
        ST_C_P: begin
          qm_r    <= 64'(q_r) * 64'(mag_c);
          rm_r    <= 50'(r_r) * 50'(mag_c);
          state_r <= ST_C_D2S;
        end
        ST_C_D2S: begin
          dreq_r  <= mk_div('0, 64'(rm_r), n64, DIV_STEPS_FULL);
          state_r <= ST_C_D2;
        end
        ST_C_D2: begin
          if (drsp.done) begin
            vn_r    <= 64'(sq_sum_r[ch_r]) - qm_r - drsp.quo;
            state_r <= ST_C_D3S;
          end
        end
        ST_C_D3S: begin
          dreq_r  <= mk_div('0, vn_r, n64, DIV_STEPS_FULL);
          state_r <= ST_C_D3;
        end
        ST_C_D3: begin
          if (drsp.done) begin
            sq_start_r <= 1'b1;
            sq_val_r   <= drsp.quo;
            state_r    <= ST_C_S;
          end
        end
        ST_C_S: begin
          if (sq_done) begin
            sd_r[ch_r] <= (sq_root > 32'hFFFF) ? 16'hFFFF : sq_root[15:0];
            if (ch_r == 2'd2) begin
              ch_r    <= '0;
              state_r <= ST_EMIT;
            end else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= ST_C_ST;
            end
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            o_channel_r <= ch_r;
            o_mean_r    <= mean_r[ch_r];
            o_sd_r      <= sd_r[ch_r];
            o_max_r     <= max_r[ch_r];
            o_rmse_r    <= rmse_r;
            o_mae_r     <= mae_r;
            o_mape_r    <= mape_r;
            o_r2_r      <= r2_r;
            o_valid_r   <= valid_r;
            o_last_r    <= (ch_r == 2'd2);
            if (ch_r == 2'd2) begin
              ch_r       <= '0;
              state_r    <= ST_IDLE;
              pair_cnt_r <= '0;
              w_tot_r    <= '0;
              wse_r      <= '0;
              wae_r      <= '0;
              wrs_r      <= '0;
              wrsq_r     <= '0;
              for (int c = 0; c < 3; c++) begin
                err_sum_r[c]  <= '0;
                sq_sum_r[c]   <= '0;
                max_r[c]      <= '0;
                ref_sum_r[c]  <= '0;
                wref_sum_r[c] <= '0;
              end
            end else begin
              ch_r <= ch_r + 2'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = o_channel_r;
  assign out_mean_error    = $signed(o_mean_r);
  assign out_std_error     = o_sd_r;
  assign out_max_abs_error = o_max_r;
  assign out_rmse          = o_rmse_r;
  assign out_mae           = o_mae_r;
  assign out_mape          = o_mape_r;
  assign out_r2_score      = $signed(o_r2_r);
  assign out_weight_valid  = o_valid_r;
  assign out_last_result   = o_last_r;

endmodule

>>> design/color_error_statistics.sv
// Top level of the color error statistics block.
//
//   channel | ports                        | moves
//   --------+------------------------------+-------------------------------
//   in      | in_valid / in_stall          | one pixel pair word
//   out     | out_valid / out_stall        | one per-channel result word
//   cfg     | cfg_we / cfg_data            | use_confidence_weight
//
// In the back part a pair word waits on the shared bit-serial divider for up to three
// ratio divisions (one per channel with a nonzero reference), then goes through the
// accumulation states. The last word of a run adds divisions and square roots
// before three result words leave the output register.
// Reset is synchronous, active low, and clears all sums; the weight mode resets to 1.
// A four-word queue lets the front take words while the back is busy or stalled.
`timescale 1ns / 1ps
module color_error_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_corrected_c0,
  input  logic [15:0]        in_corrected_c1,
  input  logic [15:0]        in_corrected_c2,
  input  logic [15:0]        in_reference_c0,
  input  logic [15:0]        in_reference_c1,
  input  logic [15:0]        in_reference_c2,
  input  logic [8:0]         in_confidence,
  input  logic               in_final_item,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_channel,
  output logic signed [16:0] out_mean_error,
  output logic [15:0]        out_std_error,
  output logic [15:0]        out_max_abs_error,
  output logic [16:0]        out_rmse,
  output logic [17:0]        out_mae,
  output logic [23:0]        out_mape,
  output logic signed [17:0] out_r2_score,
  output logic               out_weight_valid,
  output logic               out_last_result
);
  import ces_pkg::*;

  logic      push;
  ces_word_t push_data;
  logic      full;
  logic      pop;
  ces_word_t pop_data;
  logic      empty;

  ces_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_corrected_c0 (in_corrected_c0),
    .in_corrected_c1 (in_corrected_c1),
    .in_corrected_c2 (in_corrected_c2),
    .in_reference_c0 (in_reference_c0),
    .in_reference_c1 (in_reference_c1),
    .in_reference_c2 (in_reference_c2),
    .in_confidence   (in_confidence),
    .in_final_item   (in_final_item),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .push            (push),
    .push_data       (push_data),
    .full            (full)
  );

  ces_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ces_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .word_in           (pop_data),
    .word_empty        (empty),
    .word_pop          (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .out_mean_error    (out_mean_error),
    .out_std_error     (out_std_error),
    .out_max_abs_error (out_max_abs_error),
    .out_rmse          (out_rmse),
    .out_mae           (out_mae),
    .out_mape          (out_mape),
    .out_r2_score      (out_r2_score),
    .out_weight_valid  (out_weight_valid),
    .out_last_result   (out_last_result)
  );

endmodule

>>> verif/color_error_statistics_tb.sv
// Self-checking testbench for color_error_statistics: directed and random pair runs.
`timescale 1ns / 1ps
module color_error_statistics_tb;
  import ces_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 2000;

  typedef struct {
    logic [1:0]  channel;
    logic [16:0] mean_error;
    logic [15:0] std_error;
    logic [15:0] max_abs_error;
    logic [16:0] rmse;
    logic [17:0] mae;
    logic [23:0] mape;
    logic [17:0] r2_score;
    logic        weight_valid;
    logic        last_result;
  } stats_word_t;

  typedef enum int {MODE_FULL, MODE_CLOSE, MODE_ZERO_REF, MODE_FLAT_REF} pix_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_corrected_c0 = '0, in_corrected_c1 = '0, in_corrected_c2 = '0;
  logic [15:0] in_reference_c0 = '0, in_reference_c1 = '0, in_reference_c2 = '0;
  logic [8:0] in_confidence = '0;
  logic in_final_item = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_channel;
  logic signed [16:0] out_mean_error;
  logic [15:0] out_std_error, out_max_abs_error;
  logic [16:0] out_rmse;
  logic [17:0] out_mae;
  logic [23:0] out_mape;
  logic signed [17:0] out_r2_score;
  logic out_weight_valid, out_last_result;

  color_error_statistics dut (.*);

  always #5 clk = ~clk;

  // model state
  bit          weight_mode;
  bit [63:0]   n_pairs, w_total, wse, wae, wratio, wrefsq;
  bit [63:0]   sq_sum[3], max_abs[3], ref_sum[3], wref_sum[3];
  longint      err_sum[3];
  stats_word_t stats_q[$];

  int errors = 0;
  int cycles = 0;
  bit stall_busy = 1'b0;

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] sat(bit [63:0] v, bit [63:0] m);
    return v > m ? m : v;
  endfunction

  function automatic void clear_sums();
    n_pairs = 0; w_total = 0; wse = 0; wae = 0; wratio = 0; wrefsq = 0;
    for (int c = 0; c < 3; c++) begin
      err_sum[c] = 0; sq_sum[c] = 0; max_abs[c] = 0; ref_sum[c] = 0; wref_sum[c] = 0;
    end
  endfunction

  function automatic longint r2_of();
    bit [63:0] tiny, tss, q, rem, frac, m;
    longint r2;
    tiny = FULL_SCALE * FULL_SCALE * 64'd256 / 64'd1000000;
    frac = 0;
    if (n_pairs == 0) return 0;
    tss = wrefsq;
    for (int c = 0; c < 3; c++) begin
      m = (ref_sum[c] + n_pairs / 2) / n_pairs;
      tss += m * m * w_total;
      tss -= 2 * m * wref_sum[c];
    end
    if (tss <= tiny) return 0;
    q = wse / tss;
    if (q >= 9) return -131072;
    rem = wse % tss;
    for (int i = 0; i < 14; i++) begin
      rem <<= 1;
      frac <<= 1;
      if (rem >= tss) begin
        rem -= tss;
        frac |= 1;
      end
    end
    r2 = 16384 - longint'(q * 16384 + frac);
    return r2 < -131072 ? -131072 : r2;
  endfunction

  function automatic void predict_stats(bit [15:0] cor[3], bit [15:0] rf[3],
                                        bit [8:0] conf, bit fin);
    bit [63:0] w, sq_all, abs_all, ratio_all, refsq_all, ae, rmse, mae, mape;
    bit [63:0] mag, q, r, s2n, vn, sd;
    longint e, r2, mean;
    bit valid;
    stats_word_t s;
    sq_all = 0; abs_all = 0; ratio_all = 0; refsq_all = 0;
    rmse = 0; mae = 0; mape = 0; r2 = 0;
    w = weight_mode ? sat(64'(conf), 64'd256) : 64'd256;
    if (n_pairs < MAX_PAIRS) begin
      for (int c = 0; c < 3; c++) begin
        e = longint'(cor[c]) - longint'(rf[c]);
        ae = e < 0 ? -e : e;
        err_sum[c] += e;
        sq_sum[c] += ae * ae;
        if (ae > max_abs[c]) max_abs[c] = ae;
        sq_all += ae * ae;
        abs_all += ae;
        if (rf[c] != 0) ratio_all += sat((ae << 14) / rf[c], 64'd255 << 14);
        ref_sum[c] += rf[c];
        wref_sum[c] += w * rf[c];
        refsq_all += 64'(rf[c]) * rf[c];
      end
      n_pairs++;
      w_total += w;
      wse += w * sq_all;
      wae += w * abs_all;
      wratio += w * ratio_all;
      wrefsq += w * refsq_all;
    end
    if (!fin) return;
    valid = w_total != 0;
    if (valid) begin
      rmse = sat(isqrt(wse / w_total), 64'h1FFFF);
      mae = sat(wae / w_total, 64'h3FFFF);
      mape = sat((wratio * 625) / (3 * w_total * 1024), 64'hFFFFFF);
      r2 = r2_of();
    end
    for (int c = 0; c < 3; c++) begin
      mean = 0; sd = 0;
      s.max_abs_error = '0;
      if (n_pairs != 0) begin
        mag = err_sum[c] < 0 ? -err_sum[c] : err_sum[c];
        q = mag / n_pairs;
        r = mag % n_pairs;
        s2n = q * mag + (r * mag) / n_pairs;
        vn = sq_sum[c] - s2n;
        mean = err_sum[c] < 0 ? -longint'(q) : longint'(q);
        sd = sat(isqrt(vn / n_pairs), 64'hFFFF);
        s.max_abs_error = max_abs[c][15:0];
      end
      s.channel = c[1:0];
      s.mean_error = mean[16:0];
      s.std_error = sd[15:0];
      s.rmse = rmse[16:0];
      s.mae = mae[17:0];
      s.mape = mape[23:0];
      s.r2_score = r2[17:0];
      s.weight_valid = valid;
      s.last_result = (c == 2);
      stats_q.insert(stats_q.size(), s);
    end
    clear_sums();
  endfunction

  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return 0;
    if (k < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one pair word, held until taken
  task automatic send_pair(bit [15:0] cor[3], bit [15:0] rf[3], bit [8:0] conf, bit fin);
    int gap;
    bit st;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_corrected_c0 <= cor[0]; in_corrected_c1 <= cor[1]; in_corrected_c2 <= cor[2];
    in_reference_c0 <= rf[0]; in_reference_c1 <= rf[1]; in_reference_c2 <= rf[2];
    in_confidence <= conf;
    in_final_item <= fin;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    predict_stats(cor, rf, conf, fin);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_weight_mode(bit v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    weight_mode = v;
  endtask

  task automatic gen_pair(pix_mode_t mode, output bit [15:0] cor[3], output bit [15:0] rf[3]);
    int d;
    for (int c = 0; c < 3; c++) begin
      rf[c] = 16'($urandom);
      cor[c] = 16'($urandom);
      case (mode)
        MODE_CLOSE: begin
          d = $urandom_range(0, 600) - 300;
          cor[c] = 16'(int'(rf[c]) + d);
        end
        MODE_ZERO_REF: if ($urandom_range(0, 1)) rf[c] = '0;
        MODE_FLAT_REF: rf[c] = 16'd30000;
        default: ;
      endcase
    end
  endtask

  task automatic test_extremes();
    bit [15:0] z[3], f[3], h[3], a[3], b[3];
    z = '{16'h0000, 16'h0000, 16'h0000};
    f = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    h = '{16'h0001, 16'h8000, 16'h7FFF};
    // single pair set, full positive and negative errors
    send_pair(f, z, 9'd256, 1'b1);
    send_pair(z, f, 9'd256, 1'b1);
    // mixed set with zero references and over-range confidence
    send_pair(f, z, 9'd511, 1'b0);
    send_pair(z, f, 9'd257, 1'b0);
    send_pair(h, f, 9'd1, 1'b0);
    send_pair(f, h, 9'd128, 1'b1);
    // zero total weight
    send_pair(f, h, 9'd0, 1'b0);
    send_pair(h, f, 9'd0, 1'b1);
    // flat references: tiny total squares
    a = '{16'd1000, 16'd2000, 16'd3000};
    send_pair(a, a, 9'd256, 1'b0);
    send_pair(f, a, 9'd256, 1'b1);
    // small spread of references, huge error: r2 floor
    b = '{16'd1001, 16'd2001, 16'd3001};
    send_pair(f, a, 9'd200, 1'b0);
    send_pair(z, b, 9'd200, 1'b0);
    send_pair(f, a, 9'd200, 1'b1);
    // perfect match: r2 at one
    send_pair(h, h, 9'd256, 1'b0);
    send_pair(a, a, 9'd256, 1'b0);
    send_pair(f, f, 9'd256, 1'b1);
  endtask

  task automatic test_weight_mode();
    bit [15:0] a[3], b[3];
    write_weight_mode(1'b0);
    a = '{16'd100, 16'd40000, 16'd65535};
    b = '{16'd50000, 16'd0, 16'd12345};
    send_pair(a, b, 9'd0, 1'b0);
    send_pair(b, a, 9'd17, 1'b0);
    send_pair(a, a, 9'd511, 1'b1);
    write_weight_mode(1'b1);
  endtask

  task automatic test_random(int n_items);
    bit [15:0] cor[3], rf[3];
    bit [8:0] conf;
    pix_mode_t mode;
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) write_weight_mode(1'($urandom_range(0, 1)));
      len = $urandom_range(0, 3) == 0 ? $urandom_range(8, 16) : $urandom_range(1, 6);
      mode = pix_mode_t'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) mode = pix_mode_t'($urandom_range(0, 3));
        gen_pair(mode, cor, rf);
        case ($urandom_range(0, 5))
          0: conf = 9'd0;
          1: conf = 9'd256;
          2: conf = 9'($urandom_range(257, 511));
          default: conf = 9'($urandom_range(0, 256));
        endcase
        send_pair(cor, rf, conf, i == len - 1);
        sent++;
      end
    end
  endtask

  // receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (stall_busy)
      stall_busy <= $urandom_range(0, 9) != 0;
    else if ($urandom_range(0, 60) == 0)
      stall_busy <= 1'b1;
    out_stall <= stall_busy || ($urandom_range(0, 3) == 0 && cycles[9]);
  end

  // result checker
  always @(negedge clk) begin
    stats_word_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (stats_q.size() == 0) begin
        $error("unexpected result word, channel %0d", out_channel);
        errors++;
      end else begin
        x = stats_q.pop_front();
        if (out_channel !== x.channel) begin
          $error("channel exp %0d got %0d", x.channel, out_channel); errors++;
        end
        if (out_mean_error !== x.mean_error) begin
          $error("mean_error exp %0d got %0d", $signed(x.mean_error), out_mean_error);
          errors++;
        end
        if (out_std_error !== x.std_error) begin
          $error("std_error exp %0d got %0d", x.std_error, out_std_error); errors++;
        end
        if (out_max_abs_error !== x.max_abs_error) begin
          $error("max_abs_error exp %0d got %0d", x.max_abs_error, out_max_abs_error);
          errors++;
        end
        if (out_rmse !== x.rmse) begin
          $error("rmse exp %0d got %0d", x.rmse, out_rmse); errors++;
        end
        if (out_mae !== x.mae) begin
          $error("mae exp %0d got %0d", x.mae, out_mae); errors++;
        end
        if (out_mape !== x.mape) begin
          $error("mape exp %0d got %0d", x.mape, out_mape); errors++;
        end
        if (out_r2_score !== x.r2_score) begin
          $error("r2_score exp %0d got %0d", $signed(x.r2_score), out_r2_score); errors++;
        end
        if (out_weight_valid !== x.weight_valid) begin
          $error("weight_valid exp %0d got %0d", x.weight_valid, out_weight_valid);
          errors++;
        end
        if (out_last_result !== x.last_result) begin
          $error("last_result exp %0d got %0d", x.last_result, out_last_result); errors++;
        end
      end
    end
  end

  initial begin
    weight_mode = 1'b1;
    clear_sums();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_weight_mode();
    test_random(100);
    wait_idle();
    if (errors == 0 && stats_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
